// ===== src/uartrb_pkg.sv =====
package uartrb_pkg;

	localparam int RX_DEPTH_DEF = 16;
	localparam int TX_DEPTH_DEF = 16;
	localparam int BYTE_W       = 8;
	localparam int LVL_W        = 5;

	typedef enum logic [1:0] {
		FUNC_SEND    = 2'd0,
		FUNC_READ    = 2'd1,
		FUNC_RX_BYTE = 2'd2,
		FUNC_TX_MT   = 2'd3
	} func_t;

endpackage

// ===== src/uart_rx_tx_ring_buffers.sv =====
// Receive and transmit byte rings between a host and a UART, with a
// transmitter-idle flag. Each item is one event chosen by func: host send,
// host read, byte arrived from the line, or transmitter empty. An item is
// taken on any rising edge with start high; busy is always low, so one event
// per cycle is sustained. Every item gives exactly one result, shown on the
// result ports with done high for the single cycle right after the accepting
// edge. The receiver cannot stall; results must be captured
// when done is high. Ring pointers, counts and the idle flag update at the
// accepting edge, and the ring read (oldest entry at the head) is sampled at
// the same edge into the result register. A host send while the transmitter
// is idle goes straight out on tx_byte and bypasses the transmit ring. A send
// into a full transmit ring sets send_refused; a line byte into a full receive
// ring sets rx_dropped. Read results and transmit bytes read as zero when
// their valid bit is low. Levels report the fill count after the event,
// truncated to 5 bits. Ring storage is not cleared by reset; its contents are
// only ever used inside the fill count.
module uart_rx_tx_ring_buffers
	import uartrb_pkg::*;
#(
	parameter int RX_DEPTH = RX_DEPTH_DEF,
	parameter int TX_DEPTH = TX_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              done,
	input  logic [1:0]        func,
	input  logic [BYTE_W-1:0] data_byte,
	output logic              tx_load_valid,
	output logic [BYTE_W-1:0] tx_byte,
	output logic              read_valid,
	output logic [BYTE_W-1:0] read_byte,
	output logic              send_refused,
	output logic              rx_dropped,
	output logic [LVL_W-1:0]  rx_level,
	output logic [LVL_W-1:0]  tx_level,
	output logic              transmitter_idle
);

	localparam int RX_AW = $clog2(RX_DEPTH);
	localparam int TX_AW = $clog2(TX_DEPTH);
	localparam int RX_CW = $clog2(RX_DEPTH + 1);
	localparam int TX_CW = $clog2(TX_DEPTH + 1);

	// ring storage
	logic [BYTE_W-1:0] rx_mem [RX_DEPTH];
	logic [BYTE_W-1:0] tx_mem [TX_DEPTH];

	// ring state
	logic [RX_AW-1:0] rx_head_q, rx_tail_q, rx_head_d, rx_tail_d;
	logic [TX_AW-1:0] tx_head_q, tx_tail_q, tx_head_d, tx_tail_d;
	logic [RX_CW-1:0] rx_cnt_q, rx_cnt_d;
	logic [TX_CW-1:0] tx_cnt_q, tx_cnt_d;
	logic             idle_q, idle_d;

	// per-event decisions
	logic accept;
	logic rx_wr, tx_wr;
	logic load_v, load_from_ring, rd_v, refused, dropped;

	// result register
	logic              done_s1;
	logic              load_v_s1, load_ring_s1, rd_v_s1, refused_s1, dropped_s1;
	logic [BYTE_W-1:0] byte_s1, rx_rd_s1, tx_rd_s1;
	logic [RX_CW-1:0]  rx_cnt_s1;
	logic [TX_CW-1:0]  tx_cnt_s1;
	logic              idle_s1;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	function automatic logic [RX_AW-1:0] rx_inc(input logic [RX_AW-1:0] p);
		rx_inc = (p == RX_AW'(RX_DEPTH - 1)) ? '0 : p + RX_AW'(1);
	endfunction

	function automatic logic [TX_AW-1:0] tx_inc(input logic [TX_AW-1:0] p);
		tx_inc = (p == TX_AW'(TX_DEPTH - 1)) ? '0 : p + TX_AW'(1);
	endfunction

	always_comb begin
		rx_head_d      = rx_head_q;
		rx_tail_d      = rx_tail_q;
		rx_cnt_d       = rx_cnt_q;
		tx_head_d      = tx_head_q;
		tx_tail_d      = tx_tail_q;
		tx_cnt_d       = tx_cnt_q;
		idle_d         = idle_q;
		rx_wr          = 1'b0;
		tx_wr          = 1'b0;
		load_v         = 1'b0;
		load_from_ring = 1'b0;
		rd_v           = 1'b0;
		refused        = 1'b0;
		dropped        = 1'b0;
		case (func_t'(func))
			FUNC_SEND: begin
				if (idle_q) begin
					// idle transmitter: bypass the ring
					idle_d = 1'b0;
					load_v = 1'b1;
				end else if (tx_cnt_q == TX_CW'(TX_DEPTH)) begin
					refused = 1'b1;
				end else begin
					tx_wr     = 1'b1;
					tx_tail_d = tx_inc(tx_tail_q);
					tx_cnt_d  = tx_cnt_q + TX_CW'(1);
				end
			end
			FUNC_READ: begin
				if (rx_cnt_q != '0) begin
					rd_v      = 1'b1;
					rx_head_d = rx_inc(rx_head_q);
					rx_cnt_d  = rx_cnt_q - RX_CW'(1);
				end
			end
			FUNC_RX_BYTE: begin
				if (rx_cnt_q == RX_CW'(RX_DEPTH)) begin
					dropped = 1'b1;
				end else begin
					rx_wr     = 1'b1;
					rx_tail_d = rx_inc(rx_tail_q);
					rx_cnt_d  = rx_cnt_q + RX_CW'(1);
				end
			end
			FUNC_TX_MT: begin
				if (tx_cnt_q == '0) begin
					idle_d = 1'b1;
				end else begin
					load_v         = 1'b1;
					load_from_ring = 1'b1;
					tx_head_d      = tx_inc(tx_head_q);
					tx_cnt_d       = tx_cnt_q - TX_CW'(1);
					idle_d         = 1'b0;
				end
			end
			default: begin
				idle_d = idle_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_head_q <= '0;
			rx_tail_q <= '0;
			rx_cnt_q  <= '0;
			tx_head_q <= '0;
			tx_tail_q <= '0;
			tx_cnt_q  <= '0;
			idle_q    <= 1'b1;
			done_s1   <= 1'b0;
		end else begin
			done_s1 <= accept;
			if (accept) begin
				rx_head_q <= rx_head_d;
				rx_tail_q <= rx_tail_d;
				rx_cnt_q  <= rx_cnt_d;
				tx_head_q <= tx_head_d;
				tx_tail_q <= tx_tail_d;
				tx_cnt_q  <= tx_cnt_d;
				idle_q    <= idle_d;
			end
		end
	end

	// ring ports: at most one write and one head read per ring per item
	always_ff @(posedge clk) begin
		if (accept) begin
			if (rx_wr) begin
				rx_mem[rx_tail_q] <= data_byte;
			end
			if (tx_wr) begin
				tx_mem[tx_tail_q] <= data_byte;
			end
			rx_rd_s1 <= rx_mem[rx_head_q];
			tx_rd_s1 <= tx_mem[tx_head_q];
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			load_v_s1    <= load_v;
			load_ring_s1 <= load_from_ring;
			rd_v_s1      <= rd_v;
			refused_s1   <= refused;
			dropped_s1   <= dropped;
			byte_s1      <= data_byte;
			rx_cnt_s1    <= rx_cnt_d;
			tx_cnt_s1    <= tx_cnt_d;
			idle_s1      <= idle_d;
		end
	end

	assign done             = done_s1;
	assign tx_load_valid    = load_v_s1;
	assign tx_byte          = !load_v_s1   ? '0 :
	                          load_ring_s1 ? tx_rd_s1 : byte_s1;
	assign read_valid       = rd_v_s1;
	assign read_byte        = rd_v_s1 ? rx_rd_s1 : '0;
	assign send_refused     = refused_s1;
	assign rx_dropped       = dropped_s1;
	assign rx_level         = LVL_W'(rx_cnt_s1);
	assign tx_level         = LVL_W'(tx_cnt_s1);
	assign transmitter_idle = idle_s1;

endmodule

// ===== src/uartrb_chk.sv =====
module uartrb_chk
	import uartrb_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic [1:0]        func,
	input logic              tx_load_valid,
	input logic              read_valid,
	input logic              send_refused,
	input logic              rx_dropped,
	input logic              transmitter_idle
);

	// one result, in the cycle after each accepted item
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		done == $past(start && !busy))
		else $error("done does not track accepted items");

	// at most one event outcome per result
	a_one_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $onehot0({tx_load_valid, read_valid, send_refused, rx_dropped}))
		else $error("more than one outcome flag in a result");

	// read data only answers a host read
	a_read_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && func != FUNC_READ) |=> !read_valid)
		else $error("read_valid on a non-read item");

	// a byte handed to the transmitter leaves it busy
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(done && tx_load_valid) |-> !transmitter_idle)
		else $error("transmitter idle right after a load");

	// a refused send means the transmitter was busy
	a_refuse_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(done && send_refused) |-> !transmitter_idle)
		else $error("send refused while transmitter idle");

endmodule

bind uart_rx_tx_ring_buffers uartrb_chk u_chk (.*);
